[rtl/h2r_pkg.sv]
// h2r_pkg: shared types and constants for the HSV to RGB conversion pipeline.
// No dependencies; imported by h2r_frac_scale and hsv_to_rgb_convert.

package h2r_pkg;

    localparam int HUE_BITS = 16;
    localparam int REM_BITS = 12;

    localparam logic [HUE_BITS-1:0] HUE_SECTOR = 16'd3840;
    localparam logic [HUE_BITS-1:0] HUE_FULL   = 16'd23040;

    typedef logic [2:0]          sector_t;
    typedef logic [REM_BITS-1:0] rem_t;

    localparam sector_t SEC_RED     = 3'd0;
    localparam sector_t SEC_YELLOW  = 3'd1;
    localparam sector_t SEC_GREEN   = 3'd2;
    localparam sector_t SEC_CYAN    = 3'd3;
    localparam sector_t SEC_BLUE    = 3'd4;
    localparam sector_t SEC_MAGENTA = 3'd5;

    // per-stage load enables for the scaling pipeline
    typedef struct packed {
        logic round;
        logic recip;
        logic fix;
    } adv_t;

endpackage

[rtl/hsv_to_rgb_convert.sv]
// hsv_to_rgb_convert: six-stage HSV to RGB pixel pipeline.
// Each transaction passes stage 1 (sector, v*s), stage 2 (p), stages 3 to 5 (q, t) and stage 6 (output).
// Throughput: one transaction per cycle; bubbles collapse while the output stalls.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on h2r_pkg and h2r_frac_scale.

module hsv_to_rgb_convert
    import h2r_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hsv_valid,
    output logic                    hsv_stall,
    input  logic [HUE_BITS-1:0]     hue,
    input  logic [CHANNEL_BITS-1:0] saturation,
    input  logic [CHANNEL_BITS-1:0] brightness,
    output logic                    rgb_valid,
    input  logic                    rgb_stall,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue
);

    localparam int CB     = CHANNEL_BITS;
    localparam int PW     = 2*CB + REM_BITS;
    localparam int STAGES = 6;

    localparam logic [2*CB-1:0] ONE_M1 = (2*CB)'((64'd1 << CB) - 64'd1);

    logic [STAGES:1] vld_reg;
    logic [STAGES:1] vld_next;
    logic [STAGES:1] rdy;
    adv_t            adv;

    // stage 1
    logic [HUE_BITS-1:0] hue_w;
    logic [HUE_BITS-1:0] base;
    sector_t             sec_next;
    rem_t                rem_next;
    rem_t                remt_next;
    logic [2*CB-1:0]     vs_next;
    sector_t             sec1_reg;
    rem_t                rem1_reg;
    rem_t                remt1_reg;
    logic [2*CB-1:0]     vs1_reg;
    logic [CB-1:0]       v1_reg;

    // stage 2
    logic [2*CB-1:0]     vs_ceil;
    logic [CB-1:0]       p_next;
    logic [PW-1:0]       nq_next;
    logic [PW-1:0]       nt_next;
    sector_t             sec2_reg;
    logic [CB-1:0]       v2_reg;
    logic [CB-1:0]       p2_reg;
    logic [PW-1:0]       nq2_reg;
    logic [PW-1:0]       nt2_reg;

    // stages 3 to 5 side band
    sector_t             sec3_reg;
    sector_t             sec4_reg;
    sector_t             sec5_reg;
    logic [CB-1:0]       v3_reg;
    logic [CB-1:0]       v4_reg;
    logic [CB-1:0]       v5_reg;
    logic [CB-1:0]       p3_reg;
    logic [CB-1:0]       p4_reg;
    logic [CB-1:0]       p5_reg;
    logic [CB-1:0]       q5;
    logic [CB-1:0]       t5;

    // stage 6
    logic [CB-1:0]       red_next;
    logic [CB-1:0]       green_next;
    logic [CB-1:0]       blue_next;
    logic [CB-1:0]       red_reg;
    logic [CB-1:0]       green_reg;
    logic [CB-1:0]       blue_reg;

    // flow control: a stage loads when it is empty or the next stage loads
    always_comb
    begin
        rdy[STAGES] = !vld_reg[STAGES] || !rgb_stall;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign vld_next = {vld_reg[STAGES-1:1], hsv_valid};
    assign hsv_stall = !rdy[1];
    assign adv = '{round: rdy[3], recip: rdy[4], fix: rdy[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // stage 1: sector split and v*s
    always_comb
    begin
        hue_w = (hue >= HUE_FULL) ? '0 : hue;
        priority if (hue_w >= HUE_SECTOR * 16'd5)
        begin
            sec_next = SEC_MAGENTA;
            base     = HUE_SECTOR * 16'd5;
        end
        else if (hue_w >= HUE_SECTOR * 16'd4)
        begin
            sec_next = SEC_BLUE;
            base     = HUE_SECTOR * 16'd4;
        end
        else if (hue_w >= HUE_SECTOR * 16'd3)
        begin
            sec_next = SEC_CYAN;
            base     = HUE_SECTOR * 16'd3;
        end
        else if (hue_w >= HUE_SECTOR * 16'd2)
        begin
            sec_next = SEC_GREEN;
            base     = HUE_SECTOR * 16'd2;
        end
        else if (hue_w >= HUE_SECTOR)
        begin
            sec_next = SEC_YELLOW;
            base     = HUE_SECTOR;
        end
        else
        begin
            sec_next = SEC_RED;
            base     = '0;
        end
        rem_next  = REM_BITS'(hue_w - base);
        remt_next = REM_BITS'(HUE_SECTOR - HUE_BITS'(rem_next));
    end

    assign vs_next = (2*CB)'(brightness) * (2*CB)'(saturation);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sec1_reg  <= sec_next;
            rem1_reg  <= rem_next;
            remt1_reg <= remt_next;
            vs1_reg   <= vs_next;
            v1_reg    <= brightness;
        end
    end

    // stage 2: p = v - ceil(v*s / 2^CB), and v*s*f numerators for q and t
    assign vs_ceil = (vs1_reg + ONE_M1) >> CB;
    assign p_next  = v1_reg - vs_ceil[CB-1:0];
    assign nq_next = PW'(vs1_reg) * PW'(rem1_reg);
    assign nt_next = PW'(vs1_reg) * PW'(remt1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            sec2_reg <= sec1_reg;
            v2_reg   <= v1_reg;
            p2_reg   <= p_next;
            nq2_reg  <= nq_next;
            nt2_reg  <= nt_next;
        end
    end

    // stages 3 to 5
    h2r_frac_scale #(.CHANNEL_BITS(CB)) u_scale_q
    (
        .clk    (clk),
        .adv    (adv),
        .prod   (nq2_reg),
        .v      (v2_reg),
        .result (q5)
    );

    h2r_frac_scale #(.CHANNEL_BITS(CB)) u_scale_t
    (
        .clk    (clk),
        .adv    (adv),
        .prod   (nt2_reg),
        .v      (v2_reg),
        .result (t5)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            sec3_reg <= sec2_reg;
            v3_reg   <= v2_reg;
            p3_reg   <= p2_reg;
        end
        if (rdy[4])
        begin
            sec4_reg <= sec3_reg;
            v4_reg   <= v3_reg;
            p4_reg   <= p3_reg;
        end
        if (rdy[5])
        begin
            sec5_reg <= sec4_reg;
            v5_reg   <= v4_reg;
            p5_reg   <= p4_reg;
        end
    end

    // stage 6: permutation by sector
    always_comb
    begin
        unique case (sec5_reg)
            SEC_RED:
            begin
                red_next = v5_reg;  green_next = t5;     blue_next = p5_reg;
            end
            SEC_YELLOW:
            begin
                red_next = q5;      green_next = v5_reg; blue_next = p5_reg;
            end
            SEC_GREEN:
            begin
                red_next = p5_reg;  green_next = v5_reg; blue_next = t5;
            end
            SEC_CYAN:
            begin
                red_next = p5_reg;  green_next = q5;     blue_next = v5_reg;
            end
            SEC_BLUE:
            begin
                red_next = t5;      green_next = p5_reg; blue_next = v5_reg;
            end
            default:
            begin
                red_next = v5_reg;  green_next = p5_reg; blue_next = q5;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb_valid = vld_reg[STAGES];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

[rtl/h2r_frac_scale.sv]
// h2r_frac_scale: three-stage unit giving v - ceil(prod / (2^CB * 3840)).
// Division by 3840 is a shift by 8 plus a reciprocal multiply by 1/15 with
// one correction step. Depends on h2r_pkg.

module h2r_frac_scale
    import h2r_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                                clk,
    input  adv_t                                adv,
    input  logic [2*CHANNEL_BITS+REM_BITS-1:0] prod,
    input  logic [CHANNEL_BITS-1:0]            v,
    output logic [CHANNEL_BITS-1:0]            result
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 2*CB + REM_BITS;
    localparam int SW = PW + 1;
    localparam int YW = CB + 5;
    localparam int ZW = CB + 1;
    localparam int RW = CB + 2;
    localparam int SH = CB + 8;

    localparam logic [SW-1:0] BIAS  = SW'((64'd15 << SH) - 64'd1);
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << YW) / 64'd15);

    logic [SW-1:0]    biased;
    logic [YW-1:0]    y_next;
    logic [YW-1:0]    y_reg;
    logic [CB-1:0]    v1_reg;

    logic [YW+RW-1:0] recip_prod;
    logic [ZW-1:0]    z0_next;
    logic [ZW-1:0]    z0_reg;
    logic [YW-1:0]    y2_reg;
    logic [CB-1:0]    v2_reg;

    logic [YW-1:0]    fifteen_z;
    logic [YW-1:0]    resid;
    logic [ZW-1:0]    z_fix;
    logic [CB-1:0]    result_next;
    logic [CB-1:0]    result_reg;

    // ceil(prod / (15 * 2^SH)) = floor(floor((prod + bias) / 2^SH) / 15)
    assign biased = {1'b0, prod} + BIAS;
    assign y_next = biased[SW-1:SH];

    always_ff @(posedge clk)
    begin
        if (adv.round)
        begin
            y_reg  <= y_next;
            v1_reg <= v;
        end
    end

    assign recip_prod = (YW+RW)'(y_reg) * (YW+RW)'(RECIP);
    assign z0_next    = recip_prod[YW+ZW-1:YW];

    always_ff @(posedge clk)
    begin
        if (adv.recip)
        begin
            z0_reg <= z0_next;
            y2_reg <= y_reg;
            v2_reg <= v1_reg;
        end
    end

    // estimate is low by at most one
    assign fifteen_z   = {z0_reg, 4'b0000} - {4'b0000, z0_reg};
    assign resid       = y2_reg - fifteen_z;
    assign z_fix       = (resid >= YW'(15)) ? z0_reg + ZW'(1) : z0_reg;
    assign result_next = v2_reg - z_fix[CB-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.fix)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/h2r_checker.sv]
// h2r_checker: port-level assertions for hsv_to_rgb_convert, bound to it below.
// Does not import h2r_pkg; the bind passes only the top level's CHANNEL_BITS parameter.

module h2r_checker
#(
    parameter int CHANNEL_BITS = 16
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    hsv_stall,
    input logic                    rgb_valid,
    input logic                    rgb_stall,
    input logic [CHANNEL_BITS-1:0] red,
    input logic [CHANNEL_BITS-1:0] green,
    input logic [CHANNEL_BITS-1:0] blue
);

    // stalled output transaction stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("output payload changed while stalled");

    // empty output register means the pipeline can always advance
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_valid |-> !hsv_stall)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rgb_valid)
        else $error("output valid right after reset");

endmodule

bind hsv_to_rgb_convert h2r_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_h2r_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .hsv_stall (hsv_stall),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
);

[sim/tb.sv]
// tb: self-checking bench for hsv_to_rgb_convert, a directed table then random pixels
// checked against a built-in floor-rounded HSV to RGB predictor under varied idling.
// Depends on rtl/h2r_pkg.sv and rtl/hsv_to_rgb_convert.sv.

module tb
    import h2r_pkg::*;
();

    localparam int CW = 16;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [CW-1:0]       sat;
        logic [CW-1:0]       val;
        logic                known;
        rgb_t                rgb;
    } hsv_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                hsv_valid = 1'b0;
    logic                hsv_stall;
    logic [HUE_BITS-1:0] hue = '0;
    logic [CW-1:0]       saturation = '0;
    logic [CW-1:0]       brightness = '0;
    logic                rgb_valid;
    logic                rgb_stall = 1'b0;
    logic [CW-1:0]       red;
    logic [CW-1:0]       green;
    logic [CW-1:0]       blue;

    rgb_t expected_rgb [$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   pixels_sent = 0;
    int   pixels_checked = 0;
    int   mismatch_count = 0;

    // known colors (primaries and secondaries at full saturation, wrap, grey, black), then rows checked by hsv_to_rgb
    hsv_row_t hsv_rows [24] = '{
        '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
        '{16'd0,     16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd0}},
        '{16'd3840,  16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd65535, 16'd0}},
        '{16'd7680,  16'd65535, 16'd65535, 1'b1, '{16'd0,     16'd65535, 16'd0}},
        '{16'd11520, 16'd65535, 16'd65535, 1'b1, '{16'd0,     16'd65535, 16'd65535}},
        '{16'd15360, 16'd65535, 16'd65535, 1'b1, '{16'd0,     16'd0,     16'd65535}},
        '{16'd19200, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd65535}},
        '{16'd23040, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd0}},
        '{16'd65535, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd0}},
        '{16'd12345, 16'd0,     16'd40000, 1'b1, '{16'd40000, 16'd40000, 16'd40000}},
        '{16'd23039, 16'd0,     16'd65535, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
        '{16'd5000,  16'd65535, 16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
        '{16'd23039, 16'd65535, 16'd65535, 1'b0, '0},
        '{16'd3839,  16'd65535, 16'd65535, 1'b0, '0},
        '{16'd1,     16'd65535, 16'd65535, 1'b0, '0},
        '{16'd1920,  16'd32768, 16'd50000, 1'b0, '0},
        '{16'd5760,  16'd65535, 16'd1,     1'b0, '0},
        '{16'd9600,  16'd1,     16'd65535, 1'b0, '0},
        '{16'd13440, 16'd43690, 16'd21845, 1'b0, '0},
        '{16'd17280, 16'd65535, 16'd65535, 1'b0, '0},
        '{16'd21120, 16'd12345, 16'd54321, 1'b0, '0},
        '{16'd40000, 16'd30000, 16'd30000, 1'b0, '0},
        '{16'd23041, 16'd65535, 16'd32768, 1'b0, '0},
        '{16'd46080, 16'd0,     16'd65535, 1'b0, '0}
    };

    hsv_to_rgb_convert #(.CHANNEL_BITS(CW)) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rgb_t hsv_to_rgb(input logic [HUE_BITS-1:0] h,
                                        input logic [CW-1:0] s_in,
                                        input logic [CW-1:0] v_in);
        longint unsigned one, den, hv, rem, s, v, p, q, t;
        sector_t         sec;
        rgb_t            c;
        one = 64'd1 << CW;
        den = one * HUE_SECTOR;
        s   = s_in;
        v   = v_in;
        hv  = h;
        if (hv >= HUE_FULL)
            hv = 0;
        sec = sector_t'(hv / HUE_SECTOR);
        rem = hv % HUE_SECTOR;
        p = (v * (one - s)) >> CW;
        q = (v * (den - s * rem)) / den;
        t = (v * (den - s * (HUE_SECTOR - rem))) / den;
        case (sec)
            SEC_RED:    c = '{CW'(v), CW'(t), CW'(p)};
            SEC_YELLOW: c = '{CW'(q), CW'(v), CW'(p)};
            SEC_GREEN:  c = '{CW'(p), CW'(v), CW'(t)};
            SEC_CYAN:   c = '{CW'(p), CW'(q), CW'(v)};
            SEC_BLUE:   c = '{CW'(t), CW'(p), CW'(v)};
            default:    c = '{CW'(v), CW'(p), CW'(q)};
        endcase
        return c;
    endfunction

    function automatic logic [CW-1:0] rand_channel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return '1;
        else if (pick < 25)
            return CW'($urandom_range(3));
        return CW'($urandom);
    endfunction

    function automatic logic [HUE_BITS-1:0] rand_hue();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
            return HUE_BITS'($urandom_range(HUE_FULL - 1));
        else if (pick < 80)
            return HUE_BITS'($urandom_range(5) * HUE_SECTOR + $urandom_range(2))
                   - HUE_BITS'($urandom_range(1));
        return HUE_BITS'($urandom);
    endfunction

    task automatic send_pixel(input logic [HUE_BITS-1:0] h, input logic [CW-1:0] s,
                              input logic [CW-1:0] v, input rgb_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsv_valid <= 1'b0;
            @(posedge clk);
        end
        hsv_valid  <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do @(posedge clk); while (hsv_stall);
        expected_rgb = {expected_rgb, want};
        pixels_sent++;
    endtask

    task automatic wait_drained();
        hsv_valid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (expected_rgb.size() == 0)
            begin
                $display("%0t: unexpected transaction r=%h g=%h b=%h",
                         $time, red, green, blue);
                mismatch_count++;
            end
            else
            begin
                rgb_t want;
                want = expected_rgb.pop_front();
                pixels_checked++;
                if (want.red !== red)
                begin
                    $display("%0t: red mismatch expected %h actual %h", $time, want.red, red);
                    mismatch_count++;
                end
                if (want.green !== green)
                begin
                    $display("%0t: green mismatch expected %h actual %h",
                             $time, want.green, green);
                    mismatch_count++;
                end
                if (want.blue !== blue)
                begin
                    $display("%0t: blue mismatch expected %h actual %h", $time, want.blue, blue);
                    mismatch_count++;
                end
            end
        end
        rgb_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #400000;
        $display("timeout with %0d transactions outstanding", expected_rgb.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [HUE_BITS-1:0] h;
        logic [CW-1:0]       s;
        logic [CW-1:0]       v;
        int                  idle_pct [4] = '{0, 67, 0, 33};
        int                  stall_pct [4] = '{0, 0, 67, 33};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (hsv_rows[i])
            send_pixel(hsv_rows[i].hue, hsv_rows[i].sat, hsv_rows[i].val,
                       hsv_rows[i].known ? hsv_rows[i].rgb
                                         : hsv_to_rgb(hsv_rows[i].hue, hsv_rows[i].sat,
                                                      hsv_rows[i].val));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            repeat (470)
            begin
                h = rand_hue();
                s = rand_channel();
                v = rand_channel();
                send_pixel(h, s, v, hsv_to_rgb(h, s, v));
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("%0d pixels sent, %0d checked: primaries, hue wrap, grey, black, random hues",
                 pixels_sent, pixels_checked);
        $display("idling phases: none, sender 67%%, receiver 67%%, both 33%%");
        if (mismatch_count == 0 && expected_rgb.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
